FILE: rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checks a condition at every clock edge outside reset
`define ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/somr_pkg.sv
package somr_pkg;

    localparam int DIM_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam int DEF_MAX_ROWS    = 8;
    localparam int DEF_MAX_COLS    = 8;
    localparam int DEF_VALUE_WIDTH = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COL_COUNT = 2'd1;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    typedef struct packed {
        logic busy;
        logic last;
    } walk_stat_t;

    function automatic logic [DIM_W-1:0] clamp_dim(
        input logic [DIM_W-1:0] v,
        input logic [DIM_W-1:0] maxv
    );
        logic [DIM_W-1:0] res;
        priority if (v == '0)
        begin
            res = DIM_W'(1);
        end
        else if (v > maxv)
        begin
            res = maxv;
        end
        else
        begin
            res = v;
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/spiral_order_matrix_reader.sv
// channel   direction  signals
// input     in         in_valid, in_ready, element_in
// output    out        out_valid, out_ready, element_out, last_out
// config    in         cfg_valid, cfg_ready, cfg_index, cfg_data
//
// a load takes one cycle per element; in_ready drops while the spiral walk runs
// the walk issues one buffer read per cycle while out_ready stays high
// a read is issued only when the staging slot behind the buffer port is free
// reset restores both sizes to 8 and empties the walk; the buffer needs no clearing
`include "assert_macros.svh"

module spiral_order_matrix_reader #(
    parameter int MAX_ROWS    = somr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS    = somr_pkg::DEF_MAX_COLS,
    parameter int VALUE_WIDTH = somr_pkg::DEF_VALUE_WIDTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [VALUE_WIDTH-1:0]       element_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [VALUE_WIDTH-1:0]       element_out,
    output logic                                last_out,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [somr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [somr_pkg::DIM_W-1:0]          cfg_data
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [somr_pkg::DIM_W-1:0] MAX_R = somr_pkg::DIM_W'(MAX_ROWS);
    localparam logic [somr_pkg::DIM_W-1:0] MAX_C = somr_pkg::DIM_W'(MAX_COLS);

    logic [somr_pkg::DIM_W-1:0] row_reg;
    logic [somr_pkg::DIM_W-1:0] col_reg;
    logic [somr_pkg::DIM_W-1:0] rows;
    logic [somr_pkg::DIM_W-1:0] cols;

    somr_pkg::walk_stat_t       stat;
    logic                       load;
    logic                       issue;
    logic                       move;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [AW-1:0]              rd_addr;
    logic [VALUE_WIDTH-1:0]     rd_data;

    logic                       pend_valid_reg, pend_valid_next;
    logic                       pend_last_reg, pend_last_next;
    logic                       out_valid_reg, out_valid_next;
    logic                       out_last_reg;
    logic [VALUE_WIDTH-1:0]     out_elem_reg;

    assign cfg_ready = 1'b1;
    assign rows      = somr_pkg::clamp_dim(row_reg, MAX_R);
    assign cols      = somr_pkg::clamp_dim(col_reg, MAX_C);

    assign in_ready  = !stat.busy;
    assign load      = in_valid && in_ready;
    assign move      = pend_valid_reg && (!out_valid_reg || out_ready);
    assign issue     = stat.busy && (!pend_valid_reg || move);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= somr_pkg::DIM_RESET;
            col_reg <= somr_pkg::DIM_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                somr_pkg::CFG_ROW_COUNT: row_reg <= cfg_data;
                somr_pkg::CFG_COL_COUNT: col_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    somr_walk #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_walk (
        .clk     (clk),
        .rst_n   (rst_n),
        .rows    (rows),
        .cols    (cols),
        .load    (load),
        .advance (issue),
        .stat    (stat),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr)
    );

    somr_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (element_in),
        .re    (issue),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // read data waits in the ram output register until the output slot frees
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_last_next  = pend_last_reg;
        out_valid_next  = out_valid_reg;
        if (issue)
        begin
            pend_valid_next = 1'b1;
            pend_last_next  = stat.last;
        end
        else if (move)
        begin
            pend_valid_next = 1'b0;
        end
        if (move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            pend_last_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            pend_last_reg  <= pend_last_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (move)
        begin
            out_elem_reg <= rd_data;
            out_last_reg <= pend_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign element_out = out_elem_reg;
    assign last_out    = out_last_reg;

    // pending read data moves into an empty output slot without waiting for out_ready
    `ASSERT_NEXT(a_fill_out, pend_valid_reg && !out_valid_reg, out_valid_reg, "output slot not filled")

endmodule

FILE: rtl/core/somr_ram.sv
module somr_ram #(
    parameter int WIDTH = somr_pkg::DEF_VALUE_WIDTH,
    parameter int DEPTH = somr_pkg::DEF_MAX_ROWS * somr_pkg::DEF_MAX_COLS,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/somr_walk.sv
`include "assert_macros.svh"

module somr_walk #(
    parameter int MAX_ROWS = somr_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = somr_pkg::DEF_MAX_COLS,
    localparam int DEPTH   = MAX_ROWS * MAX_COLS,
    localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [somr_pkg::DIM_W-1:0]   rows,
    input  logic [somr_pkg::DIM_W-1:0]   cols,
    input  logic                         load,
    input  logic                         advance,
    output somr_pkg::walk_stat_t         stat,
    output logic                         wr_en,
    output logic [AW-1:0]                wr_addr,
    output logic [AW-1:0]                rd_addr
);

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int PW    = RW + CW + somr_pkg::DIM_W + 1;

    typedef enum logic [1:0] {
        DIR_DOWN,
        DIR_RIGHT,
        DIR_UP,
        DIR_LEFT
    } dir_t;

    logic [AW-1:0]    load_cnt_reg, load_cnt_next;
    logic             busy_reg, busy_next;
    dir_t             dir_reg, dir_next;
    logic [RW-1:0]    r_reg, r_next;
    logic [CW-1:0]    c_reg, c_next;
    logic [RW-1:0]    top_reg, top_next;
    logic [RW-1:0]    bot_reg, bot_next;
    logic [CW-1:0]    lft_reg, lft_next;
    logic [CW-1:0]    rgt_reg, rgt_next;
    logic [CNT_W-1:0] emit_cnt_reg, emit_cnt_next;

    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] load_inc;
    logic [CNT_W-1:0] emit_inc;
    logic             last_item;
    logic [PW-1:0]    addr_full;

    assign total     = CNT_W'(rows) * CNT_W'(cols);
    assign load_inc  = CNT_W'(load_cnt_reg) + CNT_W'(1);
    assign emit_inc  = emit_cnt_reg + CNT_W'(1);
    assign last_item = (emit_inc == total);
    assign addr_full = PW'(r_reg) * PW'(cols) + PW'(c_reg);

    assign stat.busy = busy_reg;
    assign stat.last = last_item;
    assign wr_en     = load;
    assign wr_addr   = load_cnt_reg;
    assign rd_addr   = addr_full[AW-1:0];

    always_comb
    begin
        load_cnt_next = load_cnt_reg;
        busy_next     = busy_reg;
        dir_next      = dir_reg;
        r_next        = r_reg;
        c_next        = c_reg;
        top_next      = top_reg;
        bot_next      = bot_reg;
        lft_next      = lft_reg;
        rgt_next      = rgt_reg;
        emit_cnt_next = emit_cnt_reg;

        if (load)
        begin
            if (load_inc >= total)
            begin
                load_cnt_next = '0;
                busy_next     = 1'b1;
                dir_next      = DIR_DOWN;
                r_next        = '0;
                c_next        = '0;
                top_next      = '0;
                lft_next      = '0;
                bot_next      = RW'(rows - somr_pkg::DIM_W'(1));
                rgt_next      = CW'(cols - somr_pkg::DIM_W'(1));
                emit_cnt_next = '0;
            end
            else
            begin
                load_cnt_next = load_cnt_reg + AW'(1);
            end
        end
        else if (busy_reg && advance)
        begin
            emit_cnt_next = emit_inc;
            if (last_item)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                unique case (dir_reg)
                    DIR_DOWN:
                    begin
                        if (r_reg < bot_reg)
                        begin
                            r_next = r_reg + RW'(1);
                        end
                        else
                        begin
                            lft_next = lft_reg + CW'(1);
                            c_next   = lft_reg + CW'(1);
                            dir_next = DIR_RIGHT;
                        end
                    end
                    DIR_RIGHT:
                    begin
                        if (c_reg < rgt_reg)
                        begin
                            c_next = c_reg + CW'(1);
                        end
                        else
                        begin
                            bot_next = bot_reg - RW'(1);
                            r_next   = bot_reg - RW'(1);
                            dir_next = DIR_UP;
                        end
                    end
                    DIR_UP:
                    begin
                        if (r_reg > top_reg)
                        begin
                            r_next = r_reg - RW'(1);
                        end
                        else
                        begin
                            rgt_next = rgt_reg - CW'(1);
                            c_next   = rgt_reg - CW'(1);
                            dir_next = DIR_LEFT;
                        end
                    end
                    DIR_LEFT:
                    begin
                        if (c_reg > lft_reg)
                        begin
                            c_next = c_reg - CW'(1);
                        end
                        else
                        begin
                            top_next = top_reg + RW'(1);
                            r_next   = top_reg + RW'(1);
                            dir_next = DIR_DOWN;
                        end
                    end
                    default:
                    begin
                        dir_next = DIR_DOWN;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_cnt_reg <= '0;
            busy_reg     <= 1'b0;
            dir_reg      <= DIR_DOWN;
            r_reg        <= '0;
            c_reg        <= '0;
            top_reg      <= '0;
            bot_reg      <= '0;
            lft_reg      <= '0;
            rgt_reg      <= '0;
            emit_cnt_reg <= '0;
        end
        else
        begin
            load_cnt_reg <= load_cnt_next;
            busy_reg     <= busy_next;
            dir_reg      <= dir_next;
            r_reg        <= r_next;
            c_reg        <= c_next;
            top_reg      <= top_next;
            bot_reg      <= bot_next;
            lft_reg      <= lft_next;
            rgt_reg      <= rgt_next;
            emit_cnt_reg <= emit_cnt_next;
        end
    end

    // walk position and count stay inside the matrix
    `ASSERT_IMPLIES(a_cnt_range, busy_reg, emit_cnt_reg < total, "emit count past total")
    `ASSERT_IMPLIES(a_addr_range, busy_reg, CNT_W'(rd_addr) < total, "read address outside matrix")
    `ASSERT_NEXT(a_last_ends, busy_reg && advance && last_item, !busy_reg, "walk not done after last")

endmodule
